/* hdl/neighbour_sum_noise_filter_macros.svh */
// Assertion macros for the neighbour sum noise filter checker.
// No dependencies; taken in by files that assert.
`ifndef NEIGHBOUR_SUM_NOISE_FILTER_MACROS_SVH
`define NEIGHBOUR_SUM_NOISE_FILTER_MACROS_SVH

// same-cycle implication
`define NSNF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsnf check failed");

// next-cycle implication
`define NSNF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsnf check failed");

`endif

/* hdl/nsnf_pkg.sv */
// Shared constants, types and helpers for the neighbour sum noise filter.
// No dependencies.
`default_nettype none

package nsnf_pkg;

   localparam int PIXEL_W         = 8;
   localparam int COLUMN_LENGTH_W = 10;
   localparam int COLUMN_COUNT_W  = 11;
   localparam int GATE_W          = 8;
   localparam int SUM_LIMIT_W     = 11;
   localparam int SUM_W           = 11;
   localparam int CSR_DATA_W      = 11;
   localparam int CSR_INDEX_W     = 2;

   localparam int MAX_COLUMN_LENGTH_DEFAULT = 512;
   localparam int MAX_COLUMNS_DEFAULT       = 1024;
   localparam int MIN_GEOMETRY              = 4;

   localparam int COLUMN_LENGTH_RESET = 480;
   localparam int COLUMN_COUNT_RESET  = 640;
   localparam int GATE_LEVEL_RESET    = 1;
   localparam int SUM_LIMIT_RESET     = 256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMN_LENGTH = 2'd0,
      CSR_COLUMN_COUNT  = 2'd1,
      CSR_GATE_LEVEL    = 2'd2,
      CSR_SUM_LIMIT     = 2'd3
   } csr_index_type;

   // per-item control travelling from the sequencer to the window stage
   typedef struct packed {
      logic decide;
      logic test;
      logic last;
   } step_type;

   function automatic int clamp_geometry(int value, int upper);
      if (value < MIN_GEOMETRY) begin
         return MIN_GEOMETRY;
      end
      if (value > upper) begin
         return upper;
      end
      return value;
   endfunction

endpackage

`default_nettype wire

/* hdl/nsnf_channels.sv */
// Valid/ready channel interfaces for pixel requests and filtered responses.
// Depends on nsnf_pkg.
`default_nettype none

interface nsnf_req_if import nsnf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface nsnf_rsp_if import nsnf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_out;
   logic               frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

/* hdl/nsnf_ram.sv */
// Generic single-clock RAM, one write and one read port, registered read (old data on
// a same-address read and write). No dependencies.
`default_nettype none

module nsnf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/nsnf_sequencer.sv */
// Input side: frame position counters, column RAM pointers and the first pipeline stage.
// Depends on nsnf_pkg and nsnf_channels.
`default_nettype none

module nsnf_sequencer import nsnf_pkg::*; #(
   parameter int MAX_COLUMN_LENGTH = MAX_COLUMN_LENGTH_DEFAULT,
   parameter int MAX_COLUMNS       = MAX_COLUMNS_DEFAULT,
   localparam int HW     = $clog2(MAX_COLUMN_LENGTH + 1),
   localparam int WW     = $clog2(MAX_COLUMNS + 1),
   localparam int AW     = $clog2(MAX_COLUMN_LENGTH),
   localparam int WARM_W = $clog2(MAX_COLUMN_LENGTH + 2)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   nsnf_req_if.sink                req_if,
   input  wire logic [HW-1:0]      height,
   input  wire logic [WW-1:0]      width,
   input  wire logic               s1_advance,
   output logic                    raw_en,
   output logic      [AW-1:0]      raw_addr,
   output logic      [PIXEL_W-1:0] raw_wr_data,
   output logic                    filt_rd_en,
   output logic      [AW-1:0]      filt_rd_addr,
   output logic                    s1_valid,
   output step_type                s1_step,
   output logic      [PIXEL_W-1:0] s1_pixel,
   output logic      [AW-1:0]      s1_slot
);

   logic [WARM_W-1:0]  warm_ff, warm_in, warm_e;
   logic [HW-1:0]      row_ff, row_in, row_e;
   logic [WW-1:0]      col_ff, col_in, col_e;
   logic [AW-1:0]      rp_ff, rp_in, rp_e;
   logic [AW-1:0]      fp_ff, fp_in, fp_e;
   logic               s1_valid_ff, s1_valid_in;
   step_type           s1_step_ff, step;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [AW-1:0]      s1_slot_ff;
   logic               accept, live, take;

   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign accept       = req_if.valid && req_if.ready;

   // frame start restarts every position before this item is placed
   always_comb begin
      if (req_if.frame_start) begin
         warm_e = '0;
         row_e  = '0;
         col_e  = '0;
         rp_e   = '0;
         fp_e   = '0;
      end else begin
         warm_e = warm_ff;
         row_e  = row_ff;
         col_e  = col_ff;
         rp_e   = rp_ff;
         fp_e   = fp_ff;
      end
   end

   assign live = col_e < width;
   assign take = accept && live;

   always_comb begin
      step.decide = live && (warm_e > WARM_W'(height));
      step.test   = (row_e > HW'(1)) && (row_e < height - HW'(1))
                    && (col_e > WW'(1)) && (col_e < width - WW'(1));
      step.last   = (col_e == width - WW'(1)) && (row_e == height - HW'(1));
   end

   always_comb begin
      warm_in     = warm_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      rp_in       = rp_ff;
      fp_in       = fp_ff;
      s1_valid_in = s1_advance ? 1'b0 : s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
         warm_in     = (warm_e > WARM_W'(height)) ? warm_e : warm_e + WARM_W'(1);
         rp_in       = (HW'(rp_e) == height - HW'(1)) ? '0 : rp_e + AW'(1);
         row_in      = row_e;
         col_in      = col_e;
         fp_in       = fp_e;
         if (step.decide) begin
            fp_in = (HW'(fp_e) == height - HW'(2)) ? '0 : fp_e + AW'(1);
            if (row_e == height - HW'(1)) begin
               row_in = '0;
               col_in = col_e + WW'(1);
            end else begin
               row_in = row_e + HW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff     <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         rp_ff       <= '0;
         fp_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         warm_ff     <= warm_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         rp_ff       <= rp_in;
         fp_ff       <= fp_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_step_ff  <= step;
         s1_pixel_ff <= req_if.pixel;
         s1_slot_ff  <= fp_e;
      end
   end

   // raw column line: read-before-write at the same slot returns the pixel one column back
   assign raw_en       = take;
   assign raw_addr     = rp_e;
   assign raw_wr_data  = req_if.pixel;
   assign filt_rd_en   = take;
   assign filt_rd_addr = fp_e;

   assign s1_valid = s1_valid_ff;
   assign s1_step  = s1_step_ff;
   assign s1_pixel = s1_pixel_ff;
   assign s1_slot  = s1_slot_ff;

endmodule

`default_nettype wire

/* hdl/nsnf_window.sv */
// 3x3 window registers, neighbour sum and clear decision, filtered write-back and
// output register. Depends on nsnf_pkg and nsnf_channels.
`default_nettype none

module nsnf_window import nsnf_pkg::*; #(
   parameter int MAX_COLUMN_LENGTH = MAX_COLUMN_LENGTH_DEFAULT,
   localparam int AW = $clog2(MAX_COLUMN_LENGTH)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   s1_valid,
   input  wire step_type               s1_step,
   input  wire logic [PIXEL_W-1:0]     s1_pixel,
   input  wire logic [AW-1:0]          s1_slot,
   input  wire logic [PIXEL_W-1:0]     raw_rd,
   input  wire logic [PIXEL_W-1:0]     filt_rd,
   input  wire logic [GATE_W-1:0]      gate_level,
   input  wire logic [SUM_LIMIT_W-1:0] sum_limit,
   output logic                        s1_advance,
   output logic                        filt_wr_en,
   output logic      [AW-1:0]          filt_wr_addr,
   output logic      [PIXEL_W-1:0]     filt_wr_data,
   nsnf_rsp_if.source                  rsp_if
);

   // left column filtered, centre column above filtered, the rest raw
   logic [PIXEL_W-1:0] left0_ff, left1_ff;
   logic [PIXEL_W-1:0] centre_ff, above_ff;
   logic [PIXEL_W-1:0] right1_ff, right2_ff;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic               out_end_ff;
   logic               out_valid_ff, out_valid_in;
   logic               fire, clear;
   logic [SUM_W-1:0]   sum;
   logic [PIXEL_W-1:0] result;

   assign s1_advance = !out_valid_ff || rsp_if.ready;
   assign fire       = s1_valid && s1_advance;

   assign sum = SUM_W'(left0_ff) + SUM_W'(left1_ff) + SUM_W'(filt_rd)
              + SUM_W'(above_ff) + SUM_W'(raw_rd)
              + SUM_W'(right2_ff) + SUM_W'(right1_ff) + SUM_W'(s1_pixel);

   assign clear  = s1_step.test && (centre_ff > gate_level) && (sum < sum_limit);
   assign result = clear ? '0 : centre_ff;

   assign filt_wr_en   = fire && s1_step.decide;
   assign filt_wr_addr = s1_slot;
   assign filt_wr_data = result;

   always_comb begin
      if (fire && s1_step.decide) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         centre_ff <= raw_rd;
         right1_ff <= s1_pixel;
         right2_ff <= right1_ff;
         left1_ff  <= filt_rd;
         left0_ff  <= left1_ff;
         if (s1_step.decide) begin
            above_ff     <= result;
            out_pixel_ff <= result;
            out_end_ff   <= s1_step.last;
         end
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.pixel_out = out_pixel_ff;
   assign rsp_if.frame_end = out_end_ff;

endmodule

`default_nettype wire

/* hdl/neighbour_sum_noise_filter.sv */
// Neighbour sum noise filter, top level: configuration registers, raw and filtered column RAMs.
// Pixel n is decided with accepted pixel n+H+1; the result passes stage 1 and the output register.
// One pixel per cycle unless rsp_if stalls; both RAMs read per pixel, raw written per pixel, filtered per decision.
// Reset (synchronous) clears positions, pipeline valids and loads the register defaults;
// RAM contents stay undefined, there is no clearing pass.
// Depends on nsnf_pkg, nsnf_channels, nsnf_ram, nsnf_sequencer, nsnf_window.
`default_nettype none

module neighbour_sum_noise_filter import nsnf_pkg::*; #(
   parameter int MAX_COLUMN_LENGTH = MAX_COLUMN_LENGTH_DEFAULT,
   parameter int MAX_COLUMNS       = MAX_COLUMNS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   nsnf_req_if.sink                   req_if,
   nsnf_rsp_if.source                 rsp_if,
   input  wire logic                  csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int HW = $clog2(MAX_COLUMN_LENGTH + 1);
   localparam int WW = $clog2(MAX_COLUMNS + 1);
   localparam int AW = $clog2(MAX_COLUMN_LENGTH);

   logic [HW-1:0]          height_ff, height_in;
   logic [WW-1:0]          width_ff, width_in;
   logic [GATE_W-1:0]      gate_ff, gate_in;
   logic [SUM_LIMIT_W-1:0] limit_ff, limit_in;

   logic               raw_en;
   logic [AW-1:0]      raw_addr;
   logic [PIXEL_W-1:0] raw_wr_data, raw_rd;
   logic               filt_rd_en, filt_wr_en;
   logic [AW-1:0]      filt_rd_addr, filt_wr_addr;
   logic [PIXEL_W-1:0] filt_wr_data, filt_rd;
   logic               s1_valid, s1_advance;
   step_type           s1_step;
   logic [PIXEL_W-1:0] s1_pixel;
   logic [AW-1:0]      s1_slot;

   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      gate_in   = gate_ff;
      limit_in  = limit_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_COLUMN_LENGTH: begin
               height_in = HW'(clamp_geometry(int'(csr_data[COLUMN_LENGTH_W-1:0]),
                                              MAX_COLUMN_LENGTH));
            end
            CSR_COLUMN_COUNT: begin
               width_in = WW'(clamp_geometry(int'(csr_data[COLUMN_COUNT_W-1:0]),
                                             MAX_COLUMNS));
            end
            CSR_GATE_LEVEL: begin
               gate_in = csr_data[GATE_W-1:0];
            end
            CSR_SUM_LIMIT: begin
               limit_in = csr_data[SUM_LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HW'(clamp_geometry(COLUMN_LENGTH_RESET, MAX_COLUMN_LENGTH));
         width_ff  <= WW'(clamp_geometry(COLUMN_COUNT_RESET, MAX_COLUMNS));
         gate_ff   <= GATE_W'(GATE_LEVEL_RESET);
         limit_ff  <= SUM_LIMIT_W'(SUM_LIMIT_RESET);
      end else begin
         height_ff <= height_in;
         width_ff  <= width_in;
         gate_ff   <= gate_in;
         limit_ff  <= limit_in;
      end
   end

   nsnf_sequencer #(
      .MAX_COLUMN_LENGTH (MAX_COLUMN_LENGTH),
      .MAX_COLUMNS       (MAX_COLUMNS)
   ) u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .height       (height_ff),
      .width        (width_ff),
      .s1_advance   (s1_advance),
      .raw_en       (raw_en),
      .raw_addr     (raw_addr),
      .raw_wr_data  (raw_wr_data),
      .filt_rd_en   (filt_rd_en),
      .filt_rd_addr (filt_rd_addr),
      .s1_valid     (s1_valid),
      .s1_step      (s1_step),
      .s1_pixel     (s1_pixel),
      .s1_slot      (s1_slot)
   );

   // raw pixels one column back
   nsnf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_COLUMN_LENGTH)
   ) u_raw_ram (
      .clock   (clock),
      .wr_en   (raw_en),
      .wr_addr (raw_addr),
      .wr_data (raw_wr_data),
      .rd_en   (raw_en),
      .rd_addr (raw_addr),
      .rd_data (raw_rd)
   );

   // decided pixels, H-1 decisions back
   nsnf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_COLUMN_LENGTH)
   ) u_filt_ram (
      .clock   (clock),
      .wr_en   (filt_wr_en),
      .wr_addr (filt_wr_addr),
      .wr_data (filt_wr_data),
      .rd_en   (filt_rd_en),
      .rd_addr (filt_rd_addr),
      .rd_data (filt_rd)
   );

   nsnf_window #(
      .MAX_COLUMN_LENGTH (MAX_COLUMN_LENGTH)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .s1_valid     (s1_valid),
      .s1_step      (s1_step),
      .s1_pixel     (s1_pixel),
      .s1_slot      (s1_slot),
      .raw_rd       (raw_rd),
      .filt_rd      (filt_rd),
      .gate_level   (gate_ff),
      .sum_limit    (limit_ff),
      .s1_advance   (s1_advance),
      .filt_wr_en   (filt_wr_en),
      .filt_wr_addr (filt_wr_addr),
      .filt_wr_data (filt_wr_data),
      .rsp_if       (rsp_if)
   );

endmodule

`default_nettype wire

/* hdl/nsnf_checker.sv */
// Port-level checks for the neighbour sum noise filter, bound to the top level.
// Depends on nsnf_pkg and neighbour_sum_noise_filter_macros.svh.
`default_nettype none

`include "neighbour_sum_noise_filter_macros.svh"

module nsnf_checker import nsnf_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               req_frame_start,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [PIXEL_W-1:0] rsp_pixel_out,
   input wire logic               rsp_frame_end
);

   `NSNF_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

   `NSNF_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_frame_end))

   // a fresh frame never yields a result from its first transfer
   `NSNF_ASSERT_IMPL(a_frame_warm_up, clock, reset, req_valid && req_ready && req_frame_start,
      ##2 (!rsp_valid || $past(rsp_valid && !rsp_ready)))

   // nothing follows the last pixel of a frame straight away
   `NSNF_ASSERT_NEXT(a_frame_gap, clock, reset, rsp_valid && rsp_ready && rsp_frame_end,
      !rsp_valid)

endmodule

bind neighbour_sum_noise_filter nsnf_checker u_nsnf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_frame_start (req_if.frame_start),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_pixel_out   (rsp_if.pixel_out),
   .rsp_frame_end   (rsp_if.frame_end)
);

`default_nettype wire
